// ===== hw/rtl/arot_pkg.sv =====
// Shared types, constants and the arctangent table for the axis rotation block.
// No dependencies; every other file takes its names from here by scope.
package arot_pkg;

	// Vertex and angle widths
	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_WIDTH = 16;

	// CORDIC: 30 steps on a 32-bit binary angle (2^31 = pi), Q1.30 vector
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W       = 5;
	localparam int BAM_W        = 32;
	localparam int Z_W          = BAM_W + 1;
	localparam int CS_W         = 33;
	localparam int FRAC_BITS    = 30;
	localparam int ANG_SHIFT    = BAM_W - ANGLE_WIDTH;

	localparam logic signed [CS_W-1:0] INV_GAIN       = CS_W'(64'sd652032874);
	localparam logic signed [Z_W-1:0]  ANG_HALF_PI    = Z_W'(64'sh4000_0000);
	localparam logic signed [Z_W-1:0]  ANG_NEG_HALF_PI = -ANG_HALF_PI;
	localparam logic signed [Z_W-1:0]  ANG_PI         = Z_W'(64'sh8000_0000);

	// Axis codes
	localparam logic [1:0] AXIS_ROLL  = 2'd0;
	localparam logic [1:0] AXIS_PITCH = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_AXIS  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE = 1'b1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_in;
		logic signed [COORD_WIDTH-1:0] y_in;
		logic signed [COORD_WIDTH-1:0] z_in;
		logic                          last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_out;
		logic signed [COORD_WIDTH-1:0] y_out;
		logic signed [COORD_WIDTH-1:0] z_out;
		logic                          last_out;
		logic                          saturated;
	} out_item_t;

	typedef struct packed {
		logic [1:0]                    axis;
		logic signed [ANGLE_WIDTH-1:0] angle;
	} cfg_t;

	// Data handed from cell to cell: fold flag, rotating vector, residual angle, vertex
	typedef struct packed {
		logic                   flip;
		logic signed [CS_W-1:0] x;
		logic signed [CS_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		in_item_t               item;
	} cordic_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return Z_W'(v);
	endfunction

endpackage

// ===== hw/rtl/arot_regs.sv =====
// Configuration registers (axis select, angle) behind an APB-style port.
// Depends on arot_pkg.
module arot_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [arot_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [arot_pkg::APB_DATA_W-1:0] pwdata,
	output logic [arot_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output arot_pkg::cfg_t                  cfg
);

	logic [arot_pkg::REG_IDX_W-1:0] idx;
	logic                           wr;
	arot_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[arot_pkg::APB_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				arot_pkg::REG_AXIS:  cfg_q.axis  <= pwdata[1:0];
				arot_pkg::REG_ANGLE: cfg_q.angle <= pwdata[arot_pkg::ANGLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read back, zero extended
	always_comb begin
		unique case (idx)
			arot_pkg::REG_AXIS:  prdata = arot_pkg::APB_DATA_W'(cfg_q.axis);
			arot_pkg::REG_ANGLE: prdata = arot_pkg::APB_DATA_W'(
				unsigned'(cfg_q.angle));
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/arot_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation plus the vertex riding along.
// Depends on arot_pkg.
module arot_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [arot_pkg::STEP_W-1:0] step,
	input  logic                        up_valid,
	input  arot_pkg::cordic_t           up,
	output logic                        dn_valid,
	output arot_pkg::cordic_t           dn
);

	logic                             valid_s1;
	arot_pkg::cordic_t                data_s1;
	arot_pkg::cordic_t                nxt;
	logic signed [arot_pkg::CS_W-1:0] xs;
	logic signed [arot_pkg::CS_W-1:0] ys;
	logic signed [arot_pkg::CS_W-1:0] xv;
	logic signed [arot_pkg::CS_W-1:0] yv;
	logic signed [arot_pkg::Z_W-1:0]  zv;
	logic signed [arot_pkg::Z_W-1:0]  at;

	// Rotate toward zero residual angle
	always_comb begin
		xv  = up.x;
		yv  = up.y;
		zv  = up.z;
		xs  = xv >>> step;
		ys  = yv >>> step;
		at  = arot_pkg::atan_step(step);
		nxt = up;
		if (!zv[arot_pkg::Z_W-1]) begin
			nxt.x = xv - ys;
			nxt.y = yv + xs;
			nxt.z = zv - at;
		end else begin
			nxt.x = xv + ys;
			nxt.y = yv - xs;
			nxt.z = zv + at;
		end
	end

	// Advance when the chain is enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn       = data_s1;

endmodule

// ===== hw/rtl/arot_combine.sv =====
// Applies cos/sin to the selected coordinate pair: sign fix, four products,
// then sum, round and saturate. Depends on arot_pkg.
module arot_combine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  arot_pkg::cfg_t       cfg,
	input  logic                 src_valid,
	input  arot_pkg::cordic_t    src,
	output logic                 res_valid,
	output arot_pkg::out_item_t  res
);

	localparam int CW     = arot_pkg::COORD_WIDTH;
	localparam int PROD_W = arot_pkg::CS_W + CW;
	localparam int SUM_W  = PROD_W + 1;
	localparam int Q_W    = SUM_W - arot_pkg::FRAC_BITS;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS =
		SUM_W'(1) <<< (arot_pkg::FRAC_BITS - 1);

	// Returns {clipped, value}
	function automatic logic [CW:0] clip(input logic signed [Q_W-1:0] q);
		logic [Q_W-CW:0] hi;
		hi = q[Q_W-1:CW-1];
		if ((&hi) || !(|hi)) begin
			return {1'b0, q[CW-1:0]};
		end else if (q[Q_W-1]) begin
			return {1'b1, 1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	logic signed [arot_pkg::CS_W-1:0] c_sel;
	logic signed [arot_pkg::CS_W-1:0] s_sel;
	logic signed [arot_pkg::CS_W-1:0] sp_sel;
	logic signed [CW-1:0]             a_sel;
	logic signed [CW-1:0]             b_sel;

	logic                             valid_s1;
	logic signed [arot_pkg::CS_W-1:0] c_s1;
	logic signed [arot_pkg::CS_W-1:0] sp_s1;
	logic signed [CW-1:0]             a_s1;
	logic signed [CW-1:0]             b_s1;
	arot_pkg::in_item_t               item_s1;

	logic                             valid_s2;
	logic signed [PROD_W-1:0]         ca_s2;
	logic signed [PROD_W-1:0]         sb_s2;
	logic signed [PROD_W-1:0]         sa_s2;
	logic signed [PROD_W-1:0]         cb_s2;
	arot_pkg::in_item_t               item_s2;

	logic signed [SUM_W-1:0]          sum0;
	logic signed [SUM_W-1:0]          sum1;
	logic signed [Q_W-1:0]            q0;
	logic signed [Q_W-1:0]            q1;
	logic [CW:0]                      r0;
	logic [CW:0]                      r1;

	// Undo the half-turn fold, flip sine for pitch, pick the coordinate pair
	always_comb begin
		c_sel  = src.flip ? -src.x : src.x;
		s_sel  = src.flip ? -src.y : src.y;
		sp_sel = (cfg.axis == arot_pkg::AXIS_PITCH) ? -s_sel : s_sel;
		unique case (cfg.axis)
			arot_pkg::AXIS_ROLL: begin
				a_sel = src.item.y_in;
				b_sel = src.item.z_in;
			end
			arot_pkg::AXIS_PITCH: begin
				a_sel = src.item.x_in;
				b_sel = src.item.z_in;
			end
			default: begin
				a_sel = src.item.x_in;
				b_sel = src.item.y_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Register selection, then the four products
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= c_sel;
			sp_s1   <= sp_sel;
			a_s1    <= a_sel;
			b_s1    <= b_sel;
			item_s1 <= src.item;
			ca_s2   <= PROD_W'(c_s1) * PROD_W'(a_s1);
			sb_s2   <= PROD_W'(sp_s1) * PROD_W'(b_s1);
			sa_s2   <= PROD_W'(sp_s1) * PROD_W'(a_s1);
			cb_s2   <= PROD_W'(c_s1) * PROD_W'(b_s1);
			item_s2 <= item_s1;
		end
	end

	// Sum, round to nearest (ties up), saturate
	always_comb begin
		sum0 = SUM_W'(ca_s2) - SUM_W'(sb_s2) + ROUND_BIAS;
		sum1 = SUM_W'(sa_s2) + SUM_W'(cb_s2) + ROUND_BIAS;
		q0   = sum0[SUM_W-1:arot_pkg::FRAC_BITS];
		q1   = sum1[SUM_W-1:arot_pkg::FRAC_BITS];
		r0   = clip(q0);
		r1   = clip(q1);
	end

	// Place results by axis; the untouched coordinate passes through
	always_comb begin
		res.x_out     = item_s2.x_in;
		res.y_out     = item_s2.y_in;
		res.z_out     = item_s2.z_in;
		res.last_out  = item_s2.last_in;
		res.saturated = 1'b0;
		unique case (cfg.axis)
			arot_pkg::AXIS_ROLL: begin
				res.y_out     = r0[CW-1:0];
				res.z_out     = r1[CW-1:0];
				res.saturated = r0[CW] | r1[CW];
			end
			arot_pkg::AXIS_PITCH: begin
				res.x_out     = r0[CW-1:0];
				res.z_out     = r1[CW-1:0];
				res.saturated = r0[CW] | r1[CW];
			end
			arot_pkg::AXIS_YAW: begin
				res.x_out     = r0[CW-1:0];
				res.y_out     = r1[CW-1:0];
				res.saturated = r0[CW] | r1[CW];
			end
			default: ;
		endcase
	end

	assign res_valid = valid_s2;

endmodule

// ===== hw/rtl/axis_rotation_3d.sv =====
// Channel  | Dir | Handshake           | Payload
// vtx      | in  | vtx_valid/vtx_stall | arot_pkg::in_item_t  (x, y, z, last)
// rot      | out | rot_valid/rot_stall | arot_pkg::out_item_t (x, y, z, last, saturated)
// apb      | in  | psel/penable/pready | axis_select @0x0, angle @0x4
//
// One item per cycle while vtx_stall is low; the accepting edge loads the angle fold
// stage, then the item passes 30 CORDIC cells, two combine stages and the output
// register before rot_valid rises.
// arst_n clears all valid flags and both configuration registers.
// A held rot_stall lets one more item land in a skid register; then the whole
// chain freezes and vtx_stall rises until the skid drains.
// Top level of the principal-axis vertex rotator; depends on arot_pkg,
// arot_regs, arot_cell and arot_combine.
module axis_rotation_3d (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [arot_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [arot_pkg::APB_DATA_W-1:0] pwdata,
	output logic [arot_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            vtx_valid,
	output logic                            vtx_stall,
	input  arot_pkg::in_item_t              vtx,
	output logic                            rot_valid,
	input  logic                            rot_stall,
	output arot_pkg::out_item_t             rot
);

	arot_pkg::cfg_t                  cfg;
	logic                            en;
	logic signed [arot_pkg::Z_W-1:0] ang_full;
	arot_pkg::cordic_t               head;

	logic                            head_valid_s1;
	arot_pkg::cordic_t               head_s1;

	logic                            chain_valid [arot_pkg::CORDIC_STEPS+1];
	arot_pkg::cordic_t               chain       [arot_pkg::CORDIC_STEPS+1];

	logic                            res_valid;
	arot_pkg::out_item_t             res;

	logic                            rot_valid_q;
	arot_pkg::out_item_t             rot_q;
	logic                            skid_valid_q;
	arot_pkg::out_item_t             skid_q;

	arot_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Freeze the chain only once the skid holds an item
	assign en        = !skid_valid_q;
	assign vtx_stall = skid_valid_q;

	// Fold the angle into +-pi/2 and load the starting vector
	always_comb begin
		ang_full  = arot_pkg::Z_W'(cfg.angle) <<< arot_pkg::ANG_SHIFT;
		head.x    = arot_pkg::INV_GAIN;
		head.y    = '0;
		head.item = vtx;
		if (ang_full > arot_pkg::ANG_HALF_PI) begin
			head.z    = ang_full - arot_pkg::ANG_PI;
			head.flip = 1'b1;
		end else if (ang_full < arot_pkg::ANG_NEG_HALF_PI) begin
			head.z    = ang_full + arot_pkg::ANG_PI;
			head.flip = 1'b1;
		end else begin
			head.z    = ang_full;
			head.flip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_s1 <= 1'b0;
		end else if (en) begin
			head_valid_s1 <= vtx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s1 <= head;
		end
	end

	assign chain_valid[0] = head_valid_s1;
	assign chain[0]       = head_s1;

	// Row of CORDIC cells, one micro-rotation each
	for (genvar i = 0; i < arot_pkg::CORDIC_STEPS; i++) begin : g_cell
		arot_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.step     (arot_pkg::STEP_W'(i)),
			.up_valid (chain_valid[i]),
			.up       (chain[i]),
			.dn_valid (chain_valid[i+1]),
			.dn       (chain[i+1])
		);
	end

	arot_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.src_valid (chain_valid[arot_pkg::CORDIC_STEPS]),
		.src       (chain[arot_pkg::CORDIC_STEPS]),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register with skid: drain skid first, else take the new item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!rot_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (rot_valid_q && rot_stall) begin
				skid_valid_q <= 1'b1;
			end else begin
				rot_valid_q <= 1'b1;
			end
		end else if (!rot_stall) begin
			rot_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!rot_stall) begin
				rot_q <= skid_q;
			end
		end else if (res_valid) begin
			if (rot_valid_q && rot_stall) begin
				skid_q <= res;
			end else begin
				rot_q <= res;
			end
		end
	end

	assign rot_valid = rot_valid_q;
	assign rot       = rot_q;

endmodule

// ===== sim/axis_rotation_3d_tb.sv =====
// Self-checking testbench for axis_rotation_3d: a directed table, then random vertex traffic
// with random idling on both channels, checked against an independent CORDIC rotation model.
// Depends on arot_pkg for port types, axis codes and register indexes.
module axis_rotation_3d_tb;

	typedef arot_pkg::in_item_t  in_item_t;
	typedef arot_pkg::out_item_t out_item_t;

	localparam int COORD_WIDTH = arot_pkg::COORD_WIDTH;
	localparam int ANGLE_WIDTH = arot_pkg::ANGLE_WIDTH;
	localparam int APB_ADDR_W  = arot_pkg::APB_ADDR_W;
	localparam int APB_DATA_W  = arot_pkg::APB_DATA_W;
	localparam int REG_IDX_W   = arot_pkg::REG_IDX_W;
	localparam logic [1:0] AXIS_ROLL  = arot_pkg::AXIS_ROLL;
	localparam logic [1:0] AXIS_PITCH = arot_pkg::AXIS_PITCH;
	localparam logic [1:0] AXIS_YAW   = arot_pkg::AXIS_YAW;
	localparam logic [REG_IDX_W-1:0] REG_AXIS  = arot_pkg::REG_AXIS;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE = arot_pkg::REG_ANGLE;

	localparam logic [1:0] AXIS_NONE = 2'd3;
	localparam logic signed [COORD_WIDTH-1:0] MAXC = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_WIDTH-1:0] MINC = 32'sh8000_0000;
	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint HALF_TURN    = 64'sd2147483648;
	localparam longint CORDIC_START = 64'sd652032874;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 40;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 110;
	localparam int DIR_ROWS    = 21;

	// atan(2^-i), 2^32 per turn
	localparam longint ATAN_STEP [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
	};

	typedef struct packed {
		logic [1:0]                    axis;
		logic signed [ANGLE_WIDTH-1:0] angle;
		in_item_t                      vertex;
		logic                          typed;
		out_item_t                     want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  vtx_valid;
	logic                  vtx_stall;
	in_item_t              vtx;
	logic                  rot_valid;
	logic                  rot_stall = 1'b0;
	out_item_t             rot;

	// Shadow of the configuration registers
	logic [1:0]                    cur_axis = AXIS_ROLL;
	logic signed [ANGLE_WIDTH-1:0] cur_angle = '0;

	out_item_t pending_rot [$];
	dir_row_t  dir_tab [DIR_ROWS];
	int        mismatches = 0;
	int        sent_cnt = 0;
	int        checked_cnt = 0;
	int        setting_cnt = 0;
	int        idle_cycles = 0;
	int        stall_left = 0;
	bit        no_idle = 1'b0;

	axis_rotation_3d u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.vtx_valid(vtx_valid),
		.vtx_stall(vtx_stall),
		.vtx      (vtx),
		.rot_valid(rot_valid),
		.rot_stall(rot_stall),
		.rot      (rot)
	);

	always #5 clk = ~clk;

	// Round a Q1.30-scaled sum to nearest (ties up) and clip to the coordinate range
	function automatic logic signed [COORD_WIDTH-1:0] round_clip(
		input logic signed [95:0] acc, inout bit sat);
		logic signed [95:0] r;
		r = (acc + 96'sd536870912) >>> 30;
		if (r > 96'sd2147483647) begin
			sat = 1'b1;
			return MAXC;
		end
		if (r < -96'sd2147483648) begin
			sat = 1'b1;
			return MINC;
		end
		return r[COORD_WIDTH-1:0];
	endfunction

	// Expected rotated vertex under the current axis and angle
	function automatic out_item_t rotate_vertex(input in_item_t v);
		longint             a, cx, sy, nx;
		bit                 flip, sat;
		logic signed [95:0] px, py, pz, c, s;
		out_item_t          r;
		a = longint'(cur_angle) * 65536;
		cx = CORDIC_START;
		sy = 0;
		flip = 1'b0;
		sat = 1'b0;
		// fold the angle into [-pi/2, pi/2]
		if (a > QUARTER_TURN) begin
			a -= HALF_TURN;
			flip = 1'b1;
		end else if (a < -QUARTER_TURN) begin
			a += HALF_TURN;
			flip = 1'b1;
		end
		for (int i = 0; i < 30; i++) begin
			if (a >= 0) begin
				nx = cx - (sy >>> i);
				sy = sy + (cx >>> i);
				a -= ATAN_STEP[i];
			end else begin
				nx = cx + (sy >>> i);
				sy = sy - (cx >>> i);
				a += ATAN_STEP[i];
			end
			cx = nx;
		end
		c = flip ? -cx : cx;
		s = flip ? -sy : sy;
		px = v.x_in;
		py = v.y_in;
		pz = v.z_in;
		r.x_out = v.x_in;
		r.y_out = v.y_in;
		r.z_out = v.z_in;
		r.last_out = v.last_in;
		case (cur_axis)
			AXIS_ROLL: begin
				r.y_out = round_clip(py * c - pz * s, sat);
				r.z_out = round_clip(py * s + pz * c, sat);
			end
			AXIS_PITCH: begin
				r.x_out = round_clip(px * c + pz * s, sat);
				r.z_out = round_clip(pz * c - px * s, sat);
			end
			AXIS_YAW: begin
				r.x_out = round_clip(px * c - py * s, sat);
				r.y_out = round_clip(px * s + py * c, sat);
			end
			default: ;
		endcase
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] random_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'(signed'($urandom_range(0, 2097151)) - 1048576);
			default: begin
				case ($urandom_range(0, 4))
					0: return MAXC;
					1: return MINC;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
		endcase
	endfunction

	function automatic in_item_t random_vertex();
		in_item_t v;
		int       mode;
		mode = $urandom_range(0, 9);
		// mostly full range, some small, some extremes, some mixed per coordinate
		if (mode <= 5)
			mode = 0;
		else if (mode <= 7)
			mode = 1;
		else if (mode == 8)
			mode = 2;
		else
			mode = -1;
		v.x_in = random_coord(mode < 0 ? $urandom_range(0, 2) : mode);
		v.y_in = random_coord(mode < 0 ? $urandom_range(0, 2) : mode);
		v.z_in = random_coord(mode < 0 ? $urandom_range(0, 2) : mode);
		v.last_in = ($urandom_range(0, 7) == 0);
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked_cnt);
		mismatches++;
	endtask

	// Drive one item after a random gap and queue its expected result on acceptance
	task automatic send_vertex(input in_item_t v, input logic typed, input out_item_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx <= v;
		vtx_valid <= 1'b1;
		do @(posedge clk); while (vtx_stall);
		pending_rot.push_back(typed ? want : rotate_vertex(v));
		sent_cnt++;
	endtask

	// Hold the sender until every queued result has arrived
	task automatic drain_results();
		vtx_valid <= 1'b0;
		@(posedge clk);
		while (pending_rot.size() != 0) @(posedge clk);
	endtask

	// Setup and access cycle; the caller releases the bus after the last write
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_AXIS)
			cur_axis = data[1:0];
		else
			cur_angle = data[ANGLE_WIDTH-1:0];
	endtask

	// Write the registers that change (both when all is set), only once the block is idle
	task automatic apply_setting(input logic [1:0] axis, input logic signed [ANGLE_WIDTH-1:0] ang,
		input bit all);
		bit new_axis, new_angle;
		new_axis = all || axis != cur_axis;
		new_angle = all || ang != cur_angle;
		if (new_axis || new_angle) begin
			drain_results();
			if (new_axis)
				write_reg(REG_AXIS, 32'(axis));
			if (new_angle)
				write_reg(REG_ANGLE, 32'(ang));
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			setting_cnt++;
		end
	endtask

	// Receive and check results, with a random stall after each one
	always @(posedge clk) begin
		if (!arst_n) begin
			rot_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (rot_valid && !rot_stall) begin
				if (pending_rot.size() == 0) begin
					report_mismatch("unexpected result x", rot.x_out, '0);
				end else begin
					out_item_t want;
					want = pending_rot.pop_front();
					if (rot.x_out !== want.x_out)
						report_mismatch("x_out", rot.x_out, want.x_out);
					if (rot.y_out !== want.y_out)
						report_mismatch("y_out", rot.y_out, want.y_out);
					if (rot.z_out !== want.z_out)
						report_mismatch("z_out", rot.z_out, want.z_out);
					if (rot.last_out !== want.last_out)
						report_mismatch("last_out", 32'(rot.last_out), 32'(want.last_out));
					if (rot.saturated !== want.saturated)
						report_mismatch("saturated", 32'(rot.saturated), 32'(want.saturated));
				end
				checked_cnt++;
				stall_left = no_idle ? 0 : $urandom_range(0, 3);
			end
			rot_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((vtx_valid && !vtx_stall) || (rot_valid && !rot_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d items still pending", pending_rot.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0]                    axis;
		logic signed [ANGLE_WIDTH-1:0] ang;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		vtx_valid <= 1'b0;
		vtx <= '0;

		// extremes, every axis, the unused axis code, quarter-turn fold edges
		dir_tab[0]  = '{AXIS_ROLL, 16'sd0, '{32'sh10000, 32'sh20000, -32'sh30000, 1'b0}, 1'b0, '0};
		dir_tab[1]  = '{AXIS_ROLL, 16'sd0, '{MAXC, MAXC, MAXC, 1'b1}, 1'b0, '0};
		dir_tab[2]  = '{AXIS_ROLL, 16'sd0, '{MINC, MINC, MINC, 1'b0}, 1'b0, '0};
		dir_tab[3]  = '{AXIS_NONE, 16'sh1234, '{MAXC, MINC, 32'sd1, 1'b1}, 1'b1,
			'{MAXC, MINC, 32'sd1, 1'b1, 1'b0}};
		dir_tab[4]  = '{AXIS_NONE, 16'sh1234, '{MINC, MAXC, -32'sd1, 1'b0}, 1'b1,
			'{MINC, MAXC, -32'sd1, 1'b0, 1'b0}};
		dir_tab[5]  = '{AXIS_ROLL, 16'sd16384, '{32'sd0, 32'sh10000, 32'sh20000, 1'b0}, 1'b0, '0};
		dir_tab[6]  = '{AXIS_ROLL, 16'sd16384, '{MAXC, MINC, MAXC, 1'b1}, 1'b0, '0};
		dir_tab[7]  = '{AXIS_PITCH, -16'sd16384, '{32'sh10000, 32'sd5, 32'sh30000, 1'b0}, 1'b0, '0};
		dir_tab[8]  = '{AXIS_PITCH, -16'sd16384, '{MINC, 32'sd0, MINC, 1'b1}, 1'b0, '0};
		dir_tab[9]  = '{AXIS_PITCH, 16'sh8000, '{32'sh12345678, -32'sd7, -32'sh0FEDCBA9, 1'b0},
			1'b0, '0};
		dir_tab[10] = '{AXIS_PITCH, 16'sh8000, '{MAXC, MAXC, MAXC, 1'b0}, 1'b0, '0};
		dir_tab[11] = '{AXIS_YAW, 16'sd32767, '{32'sh10000, 32'sh20000, MINC, 1'b0}, 1'b0, '0};
		dir_tab[12] = '{AXIS_YAW, 16'sd32767, '{MINC, MINC, 32'sd0, 1'b1}, 1'b0, '0};
		dir_tab[13] = '{AXIS_YAW, 16'sd8192, '{MAXC, MAXC, 32'sd0, 1'b0}, 1'b0, '0};
		dir_tab[14] = '{AXIS_YAW, 16'sd8192, '{MAXC, MINC, 32'sd3, 1'b0}, 1'b0, '0};
		dir_tab[15] = '{AXIS_YAW, 16'sd16385, '{32'sh10000, 32'sd0, 32'sd0, 1'b1}, 1'b0, '0};
		dir_tab[16] = '{AXIS_ROLL, -16'sd16385, '{32'sd0, 32'sh10000, 32'sh10000, 1'b0}, 1'b0, '0};
		dir_tab[17] = '{AXIS_ROLL, 16'sd1, '{-32'sd1, -32'sd1, -32'sd1, 1'b1}, 1'b0, '0};
		dir_tab[18] = '{AXIS_ROLL, -16'sd1, '{32'sd0, 32'sd1, -32'sd1, 1'b0}, 1'b0, '0};
		dir_tab[19] = '{AXIS_PITCH, 16'sd24576, '{32'sh7FFF0000, 32'sd0, -32'sh7FFF0000, 1'b0},
			1'b0, '0};
		dir_tab[20] = '{AXIS_NONE, 16'sh8000, '{32'sd0, 32'sd0, 32'sd0, 1'b1}, 1'b1,
			'{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0}};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, starting from the reset configuration
		for (int i = 0; i < DIR_ROWS; i++) begin
			apply_setting(dir_tab[i].axis, dir_tab[i].angle, 1'b0);
			send_vertex(dir_tab[i].vertex, dir_tab[i].typed, dir_tab[i].want);
		end

		// random phases: fixed extremes first, then random settings
		for (int ph = 0; ph < PHASES; ph++) begin
			axis = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
			case (ph)
				0: ang = 16'sh8000;
				1: ang = 16'sd32767;
				2: ang = 16'sd0;
				3: ang = 16'sd16384;
				default: ang = 16'($urandom);
			endcase
			apply_setting(axis, ang, 1'b1);
			no_idle = (ph % 4 == 2);
			repeat (PHASE_ITEMS) send_vertex(random_vertex(), 1'b0, '0);
		end
		no_idle = 1'b0;

		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d vertices sent and %0d results checked across %0d register settings",
			sent_cnt, checked_cnt, setting_cnt);
		$display("all four axis codes, angle and coordinate extremes covered; %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_rot.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
